@@ sv/tscq_pkg.sv @@
// shared types, defaults and elaboration-time tanh knot math for the soft-clip quantizer
// no dependencies
package tscq_pkg;

    localparam int TANH_ENTRIES_DEF = 256;
    localparam int FRAC_BITS_DEF    = 20;

    localparam logic [63:0] Q31_ONE = 64'd1 << 31;
    localparam int          EXP_TERMS = 24;
    localparam int          MAX_WHOLE = 16;

    typedef struct packed {
        logic nan;
        logic neg;
    } tscq_flags_t;

    // unsigned 64-bit quotient by restoring long division
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        int          i;
        q   = 64'd0;
        rem = 65'd0;
        for (i = 63; i >= 0; i--)
        begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den})
            begin
                rem  = rem - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // e^-f in q31 for 0 <= f <= 1.0, truncated series
    function automatic logic [63:0] exp_neg_q31(input logic [63:0] f);
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        int          k;
        term = Q31_ONE;
        pos  = Q31_ONE;
        neg  = 64'd0;
        for (k = 1; k <= EXP_TERMS; k++)
        begin
            term = udiv64((term * f) >> 31, 64'(k));
            if (k[0])
                neg = neg + term;
            else
                pos = pos + term;
        end
        return (pos > neg) ? pos - neg : 64'd0;
    endfunction

    // tanh(8k/n) in q31
    function automatic logic [63:0] tanh_q31(input int k, input int n);
        logic [63:0] e1;
        logic [63:0] y;
        logic [63:0] whole;
        logic [63:0] fr;
        logic [63:0] en;
        logic [63:0] e;
        int          j;
        e1    = exp_neg_q31(Q31_ONE);
        y     = udiv64(64'(16 * k) << 31, 64'(n));
        whole = y >> 31;
        fr    = y & (Q31_ONE - 64'd1);
        en    = Q31_ONE;
        for (j = 0; j < MAX_WHOLE; j++)
        begin
            if (64'(j) < whole)
                en = (en * e1) >> 31;
        end
        e = (en * exp_neg_q31(fr)) >> 31;
        if (e > Q31_ONE)
            e = Q31_ONE;
        return udiv64((Q31_ONE - e) << 31, Q31_ONE + e);
    endfunction

endpackage

@@ sv/tscq_f2fx.sv @@
// float bit pattern to saturated fixed-point magnitude, plus nan and sign flags
// depends on tscq_pkg
module tscq_f2fx
    import tscq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic [31:0]          bits,
    output logic [FRAC_BITS+4:0] mag,
    output tscq_flags_t          flags
);

    localparam int         AW         = FRAC_BITS + 5;
    localparam int         PAD        = 8;
    localparam int         SIG_POS    = 150;
    localparam logic [7:0] EXP_SAT    = 8'd131;
    localparam logic [7:0] EXP_ALL1   = 8'hFF;
    localparam logic [8:0] SHIFT_BASE = 9'(PAD + SIG_POS - FRAC_BITS);
    localparam logic [8:0] VEC_BITS   = 9'd32;
    localparam logic [AW-1:0] SAT_MAG = AW'(64'd16 << FRAC_BITS);

    always_comb
    begin
        logic [7:0]  ex;
        logic [23:0] sig;
        logic [8:0]  amt;
        logic [31:0] vec;
        ex  = bits[30:23];
        sig = {ex != 8'd0, bits[22:0]};
        amt = SHIFT_BASE - {1'b0, (ex == 8'd0) ? 8'd1 : ex};
        vec = {sig, {PAD{1'b0}}} >> amt;
        flags.nan = (ex == EXP_ALL1) && (bits[22:0] != 23'd0);
        flags.neg = bits[31];
        if (ex >= EXP_SAT)
            mag = SAT_MAG;
        else if (amt >= VEC_BITS)
            mag = '0;
        else
            mag = AW'(vec);
    end

endmodule

@@ sv/tanh_soft_clip_quantizer_top.sv @@
// soft-clip limiter and 16-bit pcm quantizer, nine-stage pipeline
// depends on tscq_pkg and tscq_f2fx
//
// Takes one single-precision sample per transaction on s_* and returns one signed 16-bit
// pcm sample on m_*, with m_tuser set when the input was NaN (the sample is then zero).
// Magnitudes up to 0.7 pass unchanged; above that the magnitude follows
// 0.7 + 0.3*tanh((|x|-0.7)/0.3) from an interpolated knot table, then is scaled by 32767
// and truncated. One sample is accepted every cycle unless the full pipe stalls on m_tready;
// each of the nine register stages holds at most one multiplier (constant divide, remainder
// fixup, table index, knot read, interpolation, width scaling, pcm scaling). Each stage has its
// own valid bit, so empty stages fill while a finished result waits on m_tready.
module tanh_soft_clip_quantizer_top
    import tscq_pkg::*;
#(
    parameter int TANH_ENTRIES = TANH_ENTRIES_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [31:0]        s_tdata,   // [31:0] sample_bits
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic signed [15:0] m_tdata,   // [15:0] pcm_sample
    output logic               m_tuser    // [0] was_nan
);

    localparam int NS = 9;
    localparam int AW = FRAC_BITS + 5;
    localparam int DW = FRAC_BITS + 2;
    localparam int UW = FRAC_BITS + 3;
    localparam int MW = FRAC_BITS + 4;
    localparam int IW = $clog2(TANH_ENTRIES + 1);
    localparam int F  = FRAC_BITS;

    localparam logic [63:0] ONE64    = 64'd1 << F;
    localparam logic [63:0] THRESH64 = (64'd7 * ONE64 + 64'd5) / 64'd10;
    localparam logic [63:0] WIDTH64  = ONE64 - THRESH64;
    localparam logic [63:0] RECIP64  = (64'd1 << (2 * F + 2)) / WIDTH64;
    localparam logic [63:0] SATD64   = 64'd8 * WIDTH64;

    localparam logic [F-1:0]  THRESH = THRESH64[F-1:0];
    localparam logic [F-1:0]  WIDTH  = WIDTH64[F-1:0];
    localparam logic [MW-1:0] RECIP  = RECIP64[MW-1:0];
    localparam logic [AW-1:0] SAT_D  = SATD64[AW-1:0];
    localparam logic [F:0]    ONE    = ONE64[F:0];
    localparam logic [IW-1:0] N_IDX  = IW'(TANH_ENTRIES);
    localparam logic [14:0]   PCM_SCALE = 15'd32767;

    typedef logic [F:0] knot_t;
    typedef knot_t tab_t [0:TANH_ENTRIES];

    typedef struct packed {
        logic         nan;
        logic         neg;
        logic         below;
        logic         sat;
        logic [F-1:0] pass;
    } side_t;

    function automatic tab_t build_tab();
        tab_t        tab;
        logic [63:0] q;
        int          k;
        for (k = 0; k <= TANH_ENTRIES; k++)
        begin
            q = (tanh_q31(k, TANH_ENTRIES) + (64'd1 << (30 - F))) >> (31 - F);
            if (q > ONE64)
                q = ONE64;
            if (k > 0 && q < 64'(tab[k-1]))
                q = 64'(tab[k-1]);
            tab[k] = knot_t'(q);
        end
        return tab;
    endfunction

    localparam tab_t TANH_TAB = build_tab();

    // pipeline control
    logic [NS:1] vld_reg;
    logic [NS:1] vld_next;
    logic [NS:1] adv;

    always_comb
    begin
        adv[NS] = !vld_reg[NS] || m_tready;
        for (int k = NS - 1; k >= 1; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
        vld_next[1] = adv[1] ? s_tvalid : vld_reg[1];
        for (int k = 2; k <= NS; k++)
        begin
            vld_next[k] = adv[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign s_tready = adv[1];
    assign m_tvalid = vld_reg[NS];

    // stage 1: float decode
    logic [AW-1:0] s1_mag_next;
    tscq_flags_t   s1_flg_next;
    logic [AW-1:0] s1_mag_reg;
    tscq_flags_t   s1_flg_reg;

    tscq_f2fx #(
        .FRAC_BITS(FRAC_BITS)
    ) u_f2fx (
        .bits (s_tdata),
        .mag  (s1_mag_next),
        .flags(s1_flg_next)
    );

    // stage 2: offset from threshold, reciprocal multiply
    logic [AW-1:0] s2_d;
    logic [DW-1:0] s2_d_next;
    logic [UW-1:0] s2_q0_next;
    side_t         s2_side_next;
    logic [DW-1:0] s2_d_reg;
    logic [UW-1:0] s2_q0_reg;
    side_t         s2_side_reg;

    always_comb
    begin
        logic [DW+MW-1:0] prod;
        s2_d       = s1_mag_reg - AW'(THRESH);
        s2_d_next  = DW'(s2_d);
        prod       = s2_d_next * RECIP;
        s2_q0_next = UW'(prod >> (F + 2));
        s2_side_next.nan   = s1_flg_reg.nan;
        s2_side_next.neg   = s1_flg_reg.neg;
        s2_side_next.below = s1_mag_reg <= AW'(THRESH);
        s2_side_next.sat   = s2_d >= SAT_D;
        s2_side_next.pass  = F'(s1_mag_reg);
    end

    // stage 3: quotient estimate times divisor
    logic [UW+F-1:0] s3_qw_next;
    logic [UW+F-1:0] s3_qw_reg;
    logic [UW-1:0]   s3_q0_reg;
    logic [DW-1:0]   s3_d_reg;
    side_t           s3_side_reg;

    assign s3_qw_next = s2_q0_reg * WIDTH;

    // stage 4: remainder fixup gives the tanh argument
    logic [UW-1:0] s4_u_next;
    logic [UW-1:0] s4_u_reg;
    side_t         s4_side_reg;

    always_comb
    begin
        logic [2*F+2:0] rem;
        rem       = (2*F+3)'({s3_d_reg, {F{1'b0}}}) - (2*F+3)'(s3_qw_reg);
        s4_u_next = s3_q0_reg + UW'(rem >= (2*F+3)'(WIDTH));
    end

    // stage 5: knot index and fraction
    logic [IW-1:0] s5_idx_next;
    logic [F-1:0]  s5_frac_next;
    logic [IW-1:0] s5_idx_reg;
    logic [F-1:0]  s5_frac_reg;
    side_t         s5_side_reg;

    always_comb
    begin
        logic [UW+IW-1:0] p;
        p            = s4_u_reg * N_IDX;
        s5_idx_next  = IW'(p >> (F + 3));
        s5_frac_next = F'(p >> 3);
        if (s5_idx_next >= N_IDX)
            s5_idx_next = N_IDX - IW'(1);
    end

    // stage 6: knot read
    knot_t        s6_lo_next;
    knot_t        s6_hi_next;
    knot_t        s6_lo_reg;
    knot_t        s6_hi_reg;
    logic [F-1:0] s6_frac_reg;
    side_t        s6_side_reg;

    assign s6_lo_next = TANH_TAB[s5_idx_reg];
    assign s6_hi_next = TANH_TAB[IW'(s5_idx_reg + IW'(1))];

    // stage 7: linear interpolation
    knot_t s7_th_next;
    knot_t s7_th_reg;
    side_t s7_side_reg;

    always_comb
    begin
        knot_t          diff;
        logic [2*F:0]   prod;
        diff = s6_hi_reg - s6_lo_reg;
        prod = diff * s6_frac_reg;
        if (s6_side_reg.sat)
            s7_th_next = ONE;
        else
            s7_th_next = s6_lo_reg + (F+1)'(prod >> F);
    end

    // stage 8: soft-clipped magnitude
    logic [F:0] s8_y_next;
    logic [F:0] s8_y_reg;
    side_t      s8_side_reg;

    always_comb
    begin
        logic [2*F:0] wth;
        wth = WIDTH * s7_th_reg;
        if (s7_side_reg.below)
            s8_y_next = {1'b0, s7_side_reg.pass};
        else
            s8_y_next = (F+1)'(THRESH) + (F+1)'(wth >> F);
    end

    // stage 9: pcm scaling and sign
    logic signed [15:0] out_pcm_next;
    logic signed [15:0] out_pcm_reg;
    logic               out_nan_reg;

    always_comb
    begin
        logic [F+15:0] py;
        logic [15:0]   m;
        py = s8_y_reg * PCM_SCALE;
        m  = 16'(py >> F);
        if (s8_side_reg.nan)
            out_pcm_next = '0;
        else if (s8_side_reg.neg)
            out_pcm_next = 16'(-m);
        else
            out_pcm_next = m;
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s1_mag_reg <= s1_mag_next;
            s1_flg_reg <= s1_flg_next;
        end
        if (adv[2])
        begin
            s2_d_reg    <= s2_d_next;
            s2_q0_reg   <= s2_q0_next;
            s2_side_reg <= s2_side_next;
        end
        if (adv[3])
        begin
            s3_qw_reg   <= s3_qw_next;
            s3_q0_reg   <= s2_q0_reg;
            s3_d_reg    <= s2_d_reg;
            s3_side_reg <= s2_side_reg;
        end
        if (adv[4])
        begin
            s4_u_reg    <= s4_u_next;
            s4_side_reg <= s3_side_reg;
        end
        if (adv[5])
        begin
            s5_idx_reg  <= s5_idx_next;
            s5_frac_reg <= s5_frac_next;
            s5_side_reg <= s4_side_reg;
        end
        if (adv[6])
        begin
            s6_lo_reg   <= s6_lo_next;
            s6_hi_reg   <= s6_hi_next;
            s6_frac_reg <= s5_frac_reg;
            s6_side_reg <= s5_side_reg;
        end
        if (adv[7])
        begin
            s7_th_reg   <= s7_th_next;
            s7_side_reg <= s6_side_reg;
        end
        if (adv[8])
        begin
            s8_y_reg    <= s8_y_next;
            s8_side_reg <= s7_side_reg;
        end
        if (adv[9])
        begin
            out_pcm_reg <= out_pcm_next;
            out_nan_reg <= s8_side_reg.nan;
        end
    end

    assign m_tdata = out_pcm_reg;
    assign m_tuser = out_nan_reg;

endmodule

@@ sv/tscq_checker.sv @@
// port-level assertions for the soft-clip quantizer, bound to the top level
// depends on tanh_soft_clip_quantizer_top
module tscq_port_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic signed [15:0] m_tdata,
    input logic               m_tuser
);

    localparam logic signed [15:0] PCM_MIN = 16'sh8000;

    // nan results are silent
    a_nan_silent: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == 16'sd0)
        else $error("nan transaction with nonzero pcm");

    // magnitude never exceeds full scale
    a_no_min: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata != PCM_MIN)
        else $error("pcm reached -32768");

    // input only stalls when the whole pipe backs up behind a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled with output free");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled output transaction changed");

endmodule

bind tanh_soft_clip_quantizer_top tscq_port_checker u_tscq_port_checker (.*);
